[src/blsq_pkg.sv]
// Shared types and constants for the bounded list/stack/queue block.
`default_nettype none
package blsq_pkg;

  localparam int CapW = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [2:0] {
    ACT_GET       = 3'd0,
    ACT_SET       = 3'd1,
    ACT_APPEND    = 3'd2,
    ACT_REMOVE    = 3'd3,
    ACT_POP_STACK = 3'd4,
    ACT_POP_QUEUE = 3'd5,
    ACT_CLEAR     = 3'd6
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CAPT,
    ST_SUM,
    ST_OUT
  } state_e;

  typedef struct packed {
    act_e        action;
    logic [5:0]  index;
    logic [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0]     read_value;
    logic            ok;
    logic [CapW-1:0] count_now;
  } out_item_t;

  // per-cell controls for one request
  typedef struct packed {
    logic take;
    logic wr;
    logic sh;
    logic rd;
  } cell_ctl_t;

endpackage
`default_nettype wire

[src/bounded_list_stack_queue_core.sv]
// Bounded list with stack and queue requests, built as a row of storage cells.
//
// Input channel: in_valid_i / in_stall_o carry one request (action, index,
// value). Output channel: out_valid_o / out_stall_i carry one result per
// request (word read, ok flag, count after the action).
// The cells update at the edge that takes the request, so set, append,
// remove and both pops finish their change of state at that edge; a
// remove or a queue pop moves every cell above the position down a place.
// The word read is captured in the cells, then passes a registered OR tree
// and the result register; out_valid_o rises once the result register
// holds it, and the result is taken when out_stall_i is low.
// One request is in flight at a time: no new request is taken until the
// result of the last one has been taken.
// in_stall_o stays high until the result has been taken; a stalled result
// simply holds in the output register.
// Reset clears the fill count and sets capacity to 64; entry storage is not
// cleared and is only ever read below the fill count.
// cfg_we_i writes capacity; only append looks at it.
`default_nettype none
module bounded_list_stack_queue_core #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire blsq_pkg::in_item_t            in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output blsq_pkg::out_item_t                out_item_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [blsq_pkg::CapW-1:0]     cfg_wdata_i
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > blsq_pkg::CapW) ? CntW : blsq_pkg::CapW;

  blsq_pkg::state_e state_q, state_d;
  logic [CntW-1:0]             count_q, count_d;
  logic [blsq_pkg::CapW-1:0]   cap_q;
  logic                        ok_q, ok_d;
  blsq_pkg::out_item_t         out_q, out_d;

  logic            acc;
  logic [CmpW-1:0] cnt_x, idx_x, lim_x, pos;
  logic            idx_ok, not_empty, not_full;
  logic            do_wr, do_sh, do_rd;

  logic [WORD_BITS-1:0] word [DEPTH];
  logic [WORD_BITS-1:0] rd   [DEPTH];
  logic [WORD_BITS-1:0] tree_rd;
  logic [WORD_BITS-1:0] wr_data;

  assign acc     = in_valid_i && !in_stall_o;
  assign wr_data = WORD_BITS'(in_item_i.item_value);

  // request decode against the current fill count
  always_comb begin
    cnt_x     = CmpW'(count_q);
    idx_x     = CmpW'(in_item_i.index);
    lim_x     = (CmpW'(cap_q) < CmpW'(DEPTH)) ? CmpW'(cap_q) : CmpW'(DEPTH);
    idx_ok    = idx_x < cnt_x;
    not_empty = cnt_x != '0;
    not_full  = cnt_x < lim_x;
    pos       = idx_x;
    do_wr     = 1'b0;
    do_sh     = 1'b0;
    do_rd     = 1'b0;
    ok_d      = ok_q;
    count_d   = count_q;
    if (acc) begin
      ok_d = 1'b0;
      case (in_item_i.action)
        blsq_pkg::ACT_GET: begin
          ok_d  = idx_ok;
          do_rd = idx_ok;
        end
        blsq_pkg::ACT_SET: begin
          ok_d  = idx_ok;
          do_wr = idx_ok;
        end
        blsq_pkg::ACT_APPEND: begin
          ok_d  = not_full;
          pos   = cnt_x;
          do_wr = not_full;
          if (not_full) count_d = count_q + 1'b1;
        end
        blsq_pkg::ACT_REMOVE: begin
          ok_d  = idx_ok;
          do_sh = idx_ok;
          if (idx_ok) count_d = count_q - 1'b1;
        end
        blsq_pkg::ACT_POP_STACK: begin
          ok_d  = not_empty;
          pos   = cnt_x - 1'b1;
          do_rd = not_empty;
          if (not_empty) count_d = count_q - 1'b1;
        end
        blsq_pkg::ACT_POP_QUEUE: begin
          ok_d  = not_empty;
          pos   = '0;
          do_rd = not_empty;
          do_sh = not_empty;
          if (not_empty) count_d = count_q - 1'b1;
        end
        blsq_pkg::ACT_CLEAR: begin
          ok_d    = 1'b1;
          count_d = '0;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    blsq_pkg::cell_ctl_t  ctl;
    logic [WORD_BITS-1:0] nbr;

    assign ctl.take = acc;
    assign ctl.wr   = do_wr && (pos == CmpW'(i));
    assign ctl.rd   = do_rd && (pos == CmpW'(i));
    assign ctl.sh   = do_sh && (CmpW'(i) >= pos);

    if (i == DEPTH - 1) begin : g_top
      assign nbr = word[i];
    end else begin : g_mid
      assign nbr = word[i + 1];
    end

    blsq_cell #(
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .wr_data_i(wr_data),
      .nbr_i    (nbr),
      .word_o   (word[i]),
      .rd_o     (rd[i])
    );
  end

  blsq_rd_tree #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_rd_tree (
    .clk_i(clk_i),
    .rd_i (rd),
    .rd_o (tree_rd)
  );

  always_comb begin
    state_d = state_q;
    out_d   = out_q;
    case (state_q)
      blsq_pkg::ST_IDLE: begin
        if (acc) state_d = blsq_pkg::ST_CAPT;
      end
      blsq_pkg::ST_CAPT: begin
        state_d = blsq_pkg::ST_SUM;
      end
      blsq_pkg::ST_SUM: begin
        out_d.read_value = 32'(tree_rd);
        out_d.ok         = ok_q;
        out_d.count_now  = blsq_pkg::CapW'(count_q);
        state_d          = blsq_pkg::ST_OUT;
      end
      blsq_pkg::ST_OUT: begin
        if (!out_stall_i) state_d = blsq_pkg::ST_IDLE;
      end
      default: begin
        state_d = blsq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blsq_pkg::ST_IDLE;
      count_q <= '0;
      cap_q   <= blsq_pkg::CapReset;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q  <= ok_d;
    out_q <= out_d;
  end

  assign in_stall_o  = state_q != blsq_pkg::ST_IDLE;
  assign out_valid_o = state_q == blsq_pkg::ST_OUT;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CmpW'(DEPTH))
    else $error("fill count beyond depth");

  a_append_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_item_i.action == blsq_pkg::ACT_APPEND && ok_d
    |=> count_q == $past(count_q) + 1'b1)
    else $error("append did not grow the count");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_item_i.action == blsq_pkg::ACT_CLEAR |=> count_q == '0)
    else $error("clear left entries");

  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request taken while a result is pending");

  a_count_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(count_q))
    else $error("count moved with no request taken");

endmodule
`default_nettype wire

[src/blsq_cell.sv]
// One storage cell of the list: holds a word, takes its upper neighbour's on a shift.
`default_nettype none
module blsq_cell #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire blsq_pkg::cell_ctl_t  ctl_i,
  input  wire logic [WORD_BITS-1:0] wr_data_i,
  input  wire logic [WORD_BITS-1:0] nbr_i,
  output logic      [WORD_BITS-1:0] word_o,
  output logic      [WORD_BITS-1:0] rd_o
);

  logic [WORD_BITS-1:0] word_q, word_d;
  logic [WORD_BITS-1:0] rd_q, rd_d;

  always_comb begin
    word_d = word_q;
    rd_d   = rd_q;
    if (ctl_i.take) begin
      if (ctl_i.wr) begin
        word_d = wr_data_i;
      end else if (ctl_i.sh) begin
        word_d = nbr_i;
      end
      // old word, captured before any shift lands
      rd_d = ctl_i.rd ? word_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    rd_q   <= rd_d;
  end

  assign word_o = word_q;
  assign rd_o   = rd_q;

endmodule
`default_nettype wire

[src/blsq_rd_tree.sv]
// Registered OR tree collecting the one read word from the cells; cells not read give zero.
`default_nettype none
module blsq_rd_tree #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic [WORD_BITS-1:0] rd_i [DEPTH],
  output logic      [WORD_BITS-1:0] rd_o
);

  localparam int Grp  = 32;
  localparam int NGrp = (DEPTH + Grp - 1) / Grp;

  logic [WORD_BITS-1:0] grp_q [NGrp];
  logic [WORD_BITS-1:0] grp_d [NGrp];

  for (genvar g = 0; g < NGrp; g++) begin : g_grp
    always_comb begin
      grp_d[g] = '0;
      for (int k = 0; k < Grp; k++) begin
        if (g * Grp + k < DEPTH) begin
          grp_d[g] = grp_d[g] | rd_i[g * Grp + k];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      grp_q[g] <= grp_d[g];
    end
  end

  always_comb begin
    rd_o = '0;
    for (int g = 0; g < NGrp; g++) begin
      rd_o = rd_o | grp_q[g];
    end
  end

endmodule
`default_nettype wire

[tb/tb_bounded_list_stack_queue_core.sv]
// Self-checking testbench for the bounded list/stack/queue core.
module tb_bounded_list_stack_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam logic [2:0] ACT_RESERVED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  blsq_pkg::in_item_t            in_item_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  blsq_pkg::out_item_t           out_item_o;
  logic                          cfg_we_i = 1'b0;
  logic [blsq_pkg::CapW-1:0]     cfg_wdata_i = '0;

  bounded_list_stack_queue_core #(
    .DEPTH    (DEPTH),
    .WORD_BITS(32)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the list as the block should hold it
  logic [31:0]               list_words [DEPTH];
  int unsigned               fill_model = 0;
  logic [blsq_pkg::CapW-1:0] cap_model = blsq_pkg::CapReset;

  blsq_pkg::in_item_t  pending_requests[$];
  blsq_pkg::out_item_t predicted_replies[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;

  // stimulus-side estimate of the fill count, used to aim indexes at live entries
  int unsigned shadow_count = 0;
  int unsigned shadow_limit = DEPTH;

  int unsigned drv_hold = 0, drv_run = 0;
  bit          drv_tight = 1'b0;
  int unsigned mon_hold = 0, mon_run = 0;
  bit          mon_tight = 1'b0;

  function automatic void drop_entry(int unsigned pos);
    for (int unsigned i = pos; i + 1 < fill_model; i++)
      list_words[i] = list_words[i + 1];
    fill_model--;
  endfunction

  function automatic blsq_pkg::out_item_t apply_request(blsq_pkg::in_item_t req);
    blsq_pkg::out_item_t rep;
    int unsigned         lim;
    rep = '0;
    lim = (cap_model < DEPTH) ? cap_model : DEPTH;
    case (req.action)
      blsq_pkg::ACT_GET:
        if (req.index < fill_model) begin
          rep.read_value = list_words[req.index];
          rep.ok = 1'b1;
        end
      blsq_pkg::ACT_SET:
        if (req.index < fill_model) begin
          list_words[req.index] = req.item_value;
          rep.ok = 1'b1;
        end
      blsq_pkg::ACT_APPEND:
        if (fill_model < lim) begin
          list_words[fill_model] = req.item_value;
          fill_model++;
          rep.ok = 1'b1;
        end
      blsq_pkg::ACT_REMOVE:
        if (req.index < fill_model) begin
          drop_entry(req.index);
          rep.ok = 1'b1;
        end
      blsq_pkg::ACT_POP_STACK:
        if (fill_model != 0) begin
          rep.read_value = list_words[fill_model - 1];
          fill_model--;
          rep.ok = 1'b1;
        end
      blsq_pkg::ACT_POP_QUEUE:
        if (fill_model != 0) begin
          rep.read_value = list_words[0];
          drop_entry(0);
          rep.ok = 1'b1;
        end
      blsq_pkg::ACT_CLEAR: begin
        fill_model = 0;
        rep.ok = 1'b1;
      end
      default: ;
    endcase
    rep.count_now = blsq_pkg::CapW'(fill_model);
    return rep;
  endfunction

  // mixes runs of back-to-back traffic with runs of random waits
  function automatic int unsigned pick_wait(inout int unsigned run_left, inout bit tight);
    if (run_left == 0) begin
      run_left = $urandom_range(4, 40);
      tight = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    return tight ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic blsq_pkg::in_item_t make_request(int unsigned append_pct);
    blsq_pkg::in_item_t req;
    int unsigned        roll;
    req.index = 6'($urandom_range(0, 63));
    req.item_value = $urandom;
    roll = $urandom_range(0, 15);
    if (roll == 0) req.item_value = '0;
    else if (roll == 1) req.item_value = '1;
    if ($urandom_range(0, 99) < append_pct) begin
      req.action = blsq_pkg::ACT_APPEND;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 22) req.action = blsq_pkg::ACT_GET;
      else if (roll < 40) req.action = blsq_pkg::ACT_SET;
      else if (roll < 58) req.action = blsq_pkg::ACT_REMOVE;
      else if (roll < 76) req.action = blsq_pkg::ACT_POP_STACK;
      else if (roll < 94) req.action = blsq_pkg::ACT_POP_QUEUE;
      else if (roll < 97) req.action = blsq_pkg::ACT_CLEAR;
      else req.action = blsq_pkg::act_e'(ACT_RESERVED);
    end
    // mostly valid positions, the rest random so bad indexes still turn up
    if (shadow_count != 0 && $urandom_range(0, 9) < 8)
      req.index = 6'($urandom_range(0, shadow_count - 1));
    case (req.action)
      blsq_pkg::ACT_APPEND:
        if (shadow_count < shadow_limit) shadow_count++;
      blsq_pkg::ACT_REMOVE:
        if (req.index < shadow_count) shadow_count--;
      blsq_pkg::ACT_POP_STACK, blsq_pkg::ACT_POP_QUEUE:
        if (shadow_count != 0) shadow_count--;
      blsq_pkg::ACT_CLEAR:
        shadow_count = 0;
      default: ;
    endcase
    return req;
  endfunction

  task automatic add_request(blsq_pkg::act_e act, logic [5:0] idx, logic [31:0] value);
    blsq_pkg::in_item_t req;
    req.action = act;
    req.index = idx;
    req.item_value = value;
    pending_requests.push_back(req);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || in_valid_i || predicted_replies.size() != 0);
  endtask

  task automatic random_phase(logic [blsq_pkg::CapW-1:0] cap, int unsigned n,
                              int unsigned append_pct);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_model = cap;
    @(negedge clk_i);
    shadow_limit = (cap < DEPTH) ? cap : DEPTH;
    shadow_count = fill_model;
    repeat (n) pending_requests.push_back(make_request(append_pct));
  endtask

  // request driver
  always @(posedge clk_i) begin
    bit show;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      drv_hold = 0;
    end else begin
      show = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predicted_replies.push_back(apply_request(in_item_i));
        show = 1'b0;
        drv_hold = pick_wait(drv_run, drv_tight);
      end else if (!in_valid_i && drv_hold != 0) begin
        drv_hold--;
      end
      if (!show && drv_hold == 0 && pending_requests.size() != 0) begin
        in_item_i <= pending_requests.pop_front();
        show = 1'b1;
      end
      in_valid_i <= show;
    end
  end

  // result monitor and output stall
  always @(posedge clk_i) begin
    blsq_pkg::out_item_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mon_hold = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t ns: result with none pending: expected nothing, got %h",
                   $time, out_item_o);
          mismatch_cnt++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_item_o.read_value !== want.read_value) begin
            $display("%0t ns: read_value expected %h, got %h",
                     $time, want.read_value, out_item_o.read_value);
            mismatch_cnt++;
          end
          if (out_item_o.ok !== want.ok) begin
            $display("%0t ns: ok expected %b, got %b", $time, want.ok, out_item_o.ok);
            mismatch_cnt++;
          end
          if (out_item_o.count_now !== want.count_now) begin
            $display("%0t ns: count_now expected %0d, got %0d",
                     $time, want.count_now, out_item_o.count_now);
            mismatch_cnt++;
          end
        end
        mon_hold = pick_wait(mon_run, mon_tight);
      end else if (out_valid_o && mon_hold != 0) begin
        mon_hold--;
      end
      out_stall_i <= (mon_hold != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list: both pops and every indexed request must fail; then directed requests of every kind
    add_request(blsq_pkg::ACT_POP_STACK, 6'd0, 32'h0000_0000);
    add_request(blsq_pkg::ACT_POP_QUEUE, 6'd0, 32'h0000_0000);
    add_request(blsq_pkg::ACT_GET, 6'd0, 32'h0000_0000);
    add_request(blsq_pkg::ACT_SET, 6'd0, 32'hDEAD_BEEF);
    add_request(blsq_pkg::ACT_REMOVE, 6'd0, 32'h0000_0000);
    add_request(blsq_pkg::ACT_APPEND, 6'd63, 32'hFFFF_FFFF);
    add_request(blsq_pkg::ACT_APPEND, 6'd0, 32'h0000_0000);
    add_request(blsq_pkg::ACT_APPEND, 6'd0, 32'hA5A5_A5A5);
    add_request(blsq_pkg::ACT_APPEND, 6'd0, 32'h5A5A_5A5A);
    add_request(blsq_pkg::ACT_APPEND, 6'd0, 32'h1357_9BDF);
    add_request(blsq_pkg::ACT_GET, 6'd63, 32'h0000_0000);
    add_request(blsq_pkg::ACT_GET, 6'd4, 32'h0000_0000);
    add_request(blsq_pkg::ACT_GET, 6'd0, 32'h0000_0000);
    add_request(blsq_pkg::ACT_SET, 6'd3, 32'h1234_5678);
    add_request(blsq_pkg::ACT_SET, 6'd5, 32'h8765_4321);
    add_request(blsq_pkg::ACT_REMOVE, 6'd1, 32'h0000_0000);
    add_request(blsq_pkg::ACT_REMOVE, 6'd63, 32'h0000_0000);
    add_request(blsq_pkg::ACT_POP_QUEUE, 6'd0, 32'h0000_0000);
    add_request(blsq_pkg::ACT_POP_STACK, 6'd0, 32'h0000_0000);
    add_request(blsq_pkg::act_e'(ACT_RESERVED), 6'd0, 32'hFFFF_FFFF);
    add_request(blsq_pkg::ACT_GET, 6'd0, 32'h0000_0000);
    add_request(blsq_pkg::ACT_CLEAR, 6'd0, 32'h0000_0000);
    add_request(blsq_pkg::ACT_CLEAR, 6'd0, 32'h0000_0000);
    add_request(blsq_pkg::ACT_GET, 6'd0, 32'h0000_0000);

    // capacity above the built depth, zero, one, equal to the depth, a random value below it, then above it again
    random_phase(7'd127, 250, 55);
    random_phase(7'd0, 40, 20);
    random_phase(7'd1, 60, 40);
    random_phase(7'd64, 230, 45);
    random_phase(7'($urandom_range(2, 63)), 200, 45);
    random_phase(7'd100, 150, 50);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
src/blsq_pkg.sv
src/blsq_cell.sv
src/blsq_rd_tree.sv
src/bounded_list_stack_queue_core.sv
tb/tb_bounded_list_stack_queue_core.sv
